@@ rtl/utdb_pkg.sv @@
// Shared types, token encodings and the microcode table for the transfer
// descriptor builder. No dependencies.
`default_nettype none

package utdb_pkg;

  localparam int unsigned MaxDescriptorsDefault = 64;
  localparam int unsigned MpW       = 11;
  localparam int unsigned LenW      = 16;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned WordW     = 16;
  localparam int unsigned CountW    = 15;
  localparam logic [MpW-1:0] MaxPacketReset = 11'd64;
  localparam logic [CountW-1:0] SetupLen    = 15'd8;

  typedef enum logic [1:0] {
    PID_OUT   = 2'd0,
    PID_IN    = 2'd1,
    PID_SETUP = 2'd2
  } pid_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_SIZE  = 2'd1,
    FAULT_LIMIT = 2'd2
  } fault_t;

  // program steps
  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_MUL      = 4'd1,
    S_CHK_SIZE = 4'd2,
    S_CHK_LIM  = 4'd3,
    S_CHK_KIND = 4'd4,
    S_SETUP    = 4'd5,
    S_DATA     = 4'd6,
    S_TAIL     = 4'd7,
    S_STATUS   = 4'd8,
    S_FLT_SIZE = 4'd9,
    S_FLT_LIM  = 4'd10
  } step_t;

  // jump conditions; a false condition falls through to the next step
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_NO_IN    = 3'd1,
    C_BAD_SIZE = 3'd2,
    C_OVER     = 3'd3,
    C_INTR     = 3'd4,
    C_NO_DATA  = 3'd5,
    C_MORE     = 3'd6
  } cond_t;

  // what the step puts out, if anything
  typedef enum logic [2:0] {
    K_NONE      = 3'd0,
    K_SETUP     = 3'd1,
    K_DATA      = 3'd2,
    K_STATUS    = 3'd3,
    K_FAULT_SZ  = 3'd4,
    K_FAULT_LIM = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t kind;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic in_acc;
    logic bad_size;
    logic over;
    logic intr;
    logic no_data;
    logic more;
  } flags_t;

  function automatic logic [WordW-1:0] make_token(pid_t pid, logic ioc);
    logic [WordW-1:0] t;
    t      = '0;
    t[7]   = 1'b1;    // active
    t[9:8] = pid;
    t[11:10] = 2'd1;  // error count
    t[15]  = ioc;
    return t;
  endfunction

  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    w = '{kind: K_NONE, cond: C_ALWAYS, target: S_IDLE};
    unique case (pc)
      S_IDLE:     w = '{kind: K_NONE,      cond: C_NO_IN,    target: S_IDLE};
      S_MUL:      w = '{kind: K_NONE,      cond: C_ALWAYS,   target: S_CHK_SIZE};
      S_CHK_SIZE: w = '{kind: K_NONE,      cond: C_BAD_SIZE, target: S_FLT_SIZE};
      S_CHK_LIM:  w = '{kind: K_NONE,      cond: C_OVER,     target: S_FLT_LIM};
      S_CHK_KIND: w = '{kind: K_NONE,      cond: C_INTR,     target: S_DATA};
      S_SETUP:    w = '{kind: K_SETUP,     cond: C_NO_DATA,  target: S_STATUS};
      S_DATA:     w = '{kind: K_DATA,      cond: C_MORE,     target: S_DATA};
      S_TAIL:     w = '{kind: K_NONE,      cond: C_INTR,     target: S_IDLE};
      S_STATUS:   w = '{kind: K_STATUS,    cond: C_ALWAYS,   target: S_IDLE};
      S_FLT_SIZE: w = '{kind: K_FAULT_SZ,  cond: C_ALWAYS,   target: S_IDLE};
      S_FLT_LIM:  w = '{kind: K_FAULT_LIM, cond: C_ALWAYS,   target: S_IDLE};
      default:    w = '{kind: K_NONE,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/utdb_seq.sv @@
// Microprogram sequencer: step counter, control word table and jump logic.
// Depends on utdb_pkg.
`default_nettype none

module utdb_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire utdb_pkg::flags_t flags,
  input  wire logic            out_free,
  output utdb_pkg::ucode_t     uword,
  output utdb_pkg::step_t      pc,
  output logic                 emit
);

  utdb_pkg::step_t pc_next;
  logic            cond_true;

  assign uword = utdb_pkg::ucode_rom(pc);
  assign emit  = (uword.kind != utdb_pkg::K_NONE);

  always_comb begin
    unique case (uword.cond)
      utdb_pkg::C_ALWAYS:   cond_true = 1'b1;
      utdb_pkg::C_NO_IN:    cond_true = !flags.in_acc;
      utdb_pkg::C_BAD_SIZE: cond_true = flags.bad_size;
      utdb_pkg::C_OVER:     cond_true = flags.over;
      utdb_pkg::C_INTR:     cond_true = flags.intr;
      utdb_pkg::C_NO_DATA:  cond_true = flags.no_data;
      utdb_pkg::C_MORE:     cond_true = flags.more;
      default:              cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (emit && !out_free) begin
      pc_next = pc;  // result register still full
    end else if (cond_true) begin
      pc_next = uword.target;
    end else begin
      pc_next = utdb_pkg::step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= utdb_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/usb_transfer_descriptor_builder_unit.sv @@
// Top level of the transfer descriptor builder: request latch, packet
// datapath and result register around the microprogram sequencer.
// Depends on utdb_pkg and utdb_seq.
//
//  channel | direction | tdata / data                         | tuser / tlast
//  in_*    | in        | dir_out, setup addr, data addr, len  | tuser: op
//  out_*   | out       | token, length word, buffer pointer   | tuser: fault, tlast: final
//  cfg_*   | in        | max_packet                           | -
//
// A request is taken only while the sequencer sits idle. After the request beat
// four set-up steps (limit multiply, size check, limit check, kind check) pass
// before the first descriptor, then one descriptor a cycle leaves through the
// result register while it is free, and one more step follows the data packets.
// A fault ends the transfer with a single fault beat, and a control transfer
// with no data goes from its setup descriptor straight to its status descriptor.
// A stalled result register holds the sequencer on its current step.
// Synchronous reset returns the sequencer to idle and max_packet to 64.
`default_nettype none

module usb_transfer_descriptor_builder_unit #(
  parameter int unsigned MAX_DESCRIPTORS = utdb_pkg::MaxDescriptorsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // direction_out[0], setup_address[32:1],
                                       // data_address[64:33], data_length[80:65]
  input  wire logic [0:0]  in_tuser,   // op[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // token_word[15:0], length_word[31:16],
                                       // buffer_pointer[63:32]
  output logic [1:0]       out_tuser,  // fault[1:0]
  output logic             out_tlast,  // final_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data    // max_packet[10:0]
);

  localparam int unsigned LimW  = $clog2(MAX_DESCRIPTORS + 1);
  localparam int unsigned ProdW = LimW + utdb_pkg::MpW;
  localparam int unsigned CmpW  = (ProdW > utdb_pkg::LenW) ? ProdW : utdb_pkg::LenW;

  logic [utdb_pkg::MpW-1:0]   max_packet;
  logic                       op_r;
  logic                       dir_r;
  logic [utdb_pkg::AddrW-1:0] setup_r;
  logic [utdb_pkg::AddrW-1:0] addr_r;
  logic [utdb_pkg::LenW-1:0]  rem_r;
  logic                       toggle_r;
  logic [ProdW-1:0]           prod_r;

  utdb_pkg::flags_t flags;
  utdb_pkg::ucode_t uword;
  utdb_pkg::step_t  pc;
  logic             emit;
  logic             out_free;
  logic             in_acc;
  logic             step_out;
  logic [LimW-1:0]  limit;
  logic [utdb_pkg::CountW-1:0] pkt_len;
  utdb_pkg::pid_t   data_pid;
  utdb_pkg::pid_t   status_pid;

  assign cfg_ready = 1'b1;
  assign in_tready = (pc == utdb_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;
  assign step_out  = emit && out_free;

  assign limit = op_r ? LimW'(MAX_DESCRIPTORS) : LimW'(MAX_DESCRIPTORS - 2);

  assign flags.in_acc   = in_acc;
  assign flags.bad_size = (max_packet == '0) || (op_r && rem_r == '0);
  // ceil(len / mp) > lim exactly when len > lim * mp
  assign flags.over     = CmpW'(rem_r) > CmpW'(prod_r);
  assign flags.intr     = op_r;
  assign flags.no_data  = (rem_r == '0);
  assign flags.more     = rem_r > utdb_pkg::LenW'(max_packet);

  assign pkt_len    = flags.more ? utdb_pkg::CountW'(max_packet) : utdb_pkg::CountW'(rem_r);
  assign data_pid   = (!op_r && dir_r) ? utdb_pkg::PID_OUT : utdb_pkg::PID_IN;
  assign status_pid = dir_r ? utdb_pkg::PID_IN : utdb_pkg::PID_OUT;

  utdb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .out_free (out_free),
    .uword    (uword),
    .pc       (pc),
    .emit     (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet <= utdb_pkg::MaxPacketReset;
    end else if (cfg_valid && cfg_ready) begin
      max_packet <= cfg_data;
    end
  end

  // request latch and per-packet state
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_tuser[0];
      dir_r    <= in_tdata[0];
      setup_r  <= in_tdata[32:1];
      addr_r   <= in_tdata[64:33];
      rem_r    <= in_tdata[80:65];
      toggle_r <= !in_tuser[0];  // control data starts at toggle 1
    end else if (pc == utdb_pkg::S_MUL) begin
      prod_r <= ProdW'(limit) * ProdW'(max_packet);
    end else if (step_out && uword.kind == utdb_pkg::K_DATA) begin
      addr_r   <= addr_r + utdb_pkg::AddrW'(max_packet);
      rem_r    <= rem_r - utdb_pkg::LenW'(pkt_len);
      toggle_r <= !toggle_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (step_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_out) begin
      case (uword.kind)
        utdb_pkg::K_SETUP: begin
          out_tdata <= {setup_r, 1'b0, utdb_pkg::SetupLen,
                        utdb_pkg::make_token(utdb_pkg::PID_SETUP, 1'b0)};
          out_tuser <= utdb_pkg::FAULT_NONE;
          out_tlast <= 1'b0;
        end
        utdb_pkg::K_DATA: begin
          out_tdata <= {addr_r, toggle_r, pkt_len,
                        utdb_pkg::make_token(data_pid, op_r && !flags.more)};
          out_tuser <= utdb_pkg::FAULT_NONE;
          out_tlast <= op_r && !flags.more;
        end
        utdb_pkg::K_STATUS: begin
          out_tdata <= {utdb_pkg::AddrW'(0), 1'b1, utdb_pkg::CountW'(0),
                        utdb_pkg::make_token(status_pid, 1'b1)};
          out_tuser <= utdb_pkg::FAULT_NONE;
          out_tlast <= 1'b1;
        end
        utdb_pkg::K_FAULT_SZ: begin
          out_tdata <= '0;
          out_tuser <= utdb_pkg::FAULT_SIZE;
          out_tlast <= 1'b1;
        end
        default: begin
          out_tdata <= '0;
          out_tuser <= utdb_pkg::FAULT_LIMIT;
          out_tlast <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/utdb_checker.sv @@
// Port-level checks for the transfer descriptor builder, bound to the top.
// Depends on utdb_pkg and usb_transfer_descriptor_builder_unit.
`default_nettype none

module utdb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result beat changed");

  // a fault beat ends the transfer and carries no descriptor
  a_fault_beat: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && out_tuser != utdb_pkg::FAULT_NONE |-> out_tlast && out_tdata == '0)
    else $error("fault beat malformed");

  // every good descriptor is active with error count one
  a_token: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && out_tuser == utdb_pkg::FAULT_NONE |-> out_tdata[7] && out_tdata[11:10] == 2'd1)
    else $error("token word malformed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_reset: assert property (@(posedge clk) rst |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind usb_transfer_descriptor_builder_unit utdb_checker u_utdb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

@@ sim/utdb_chain_checker.sv @@
// Descriptor chain checker: watches the request, config and result channels,
// predicts each transfer's descriptor beats and compares them in order.
// Depends on utdb_pkg for the PID and fault encodings, limit and reset packet size.
module utdb_chain_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [87:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [10:0] cfg_data,
  output int               failures,
  output int               pending
);

  localparam int unsigned ChainLimit = utdb_pkg::MaxDescriptorsDefault;

  typedef struct {
    logic [15:0]      token;
    logic [15:0]      length;
    logic [31:0]      buffer;
    logic             final_res;
    utdb_pkg::fault_t fault;
  } desc_t;

  desc_t       desc_q[$];
  int unsigned max_packet;

  function automatic logic [15:0] token_of(utdb_pkg::pid_t pid, logic ioc);
    return {ioc, 3'b000, 2'd1, pid, 1'b1, 7'd0};
  endfunction

  task automatic push_desc(input utdb_pkg::pid_t pid, input logic ioc,
                           input int unsigned count, input logic toggle,
                           input logic [31:0] buffer, input logic last);
    desc_t d;
    d.token     = token_of(pid, ioc);
    d.length    = {toggle, count[14:0]};
    d.buffer    = buffer;
    d.final_res = last;
    d.fault     = utdb_pkg::FAULT_NONE;
    desc_q.push_back(d);
  endtask

  task automatic push_fault(input utdb_pkg::fault_t code);
    desc_t d;
    d.token     = '0;
    d.length    = '0;
    d.buffer    = '0;
    d.final_res = 1'b1;
    d.fault     = code;
    desc_q.push_back(d);
  endtask

  task automatic predict_chain(input logic intr, input logic dir_out,
                               input logic [31:0] setup_addr, input logic [31:0] data_addr,
                               input logic [15:0] len);
    int unsigned    npk, total, off, n;
    logic           toggle, last;
    utdb_pkg::pid_t pid;
    if (max_packet == 0 || (intr && len == 0)) begin
      push_fault(utdb_pkg::FAULT_SIZE);
      return;
    end
    npk   = (len + max_packet - 1) / max_packet;
    total = intr ? npk : npk + 2;
    if (total > ChainLimit) begin
      push_fault(utdb_pkg::FAULT_LIMIT);
      return;
    end
    if (!intr) begin
      push_desc(utdb_pkg::PID_SETUP, 1'b0, 8, 1'b0, setup_addr, 1'b0);
      pid    = dir_out ? utdb_pkg::PID_OUT : utdb_pkg::PID_IN;
      toggle = 1'b1;
    end else begin
      pid    = utdb_pkg::PID_IN;
      toggle = 1'b0;
    end
    for (off = 0; off < len; off += max_packet) begin
      n    = (len - off > max_packet) ? max_packet : len - off;
      last = (off + n >= len);
      push_desc(pid, intr && last, n, toggle, data_addr + off[31:0], intr && last);
      toggle = !toggle;
    end
    // status stage runs against the data direction
    if (!intr)
      push_desc(dir_out ? utdb_pkg::PID_IN : utdb_pkg::PID_OUT, 1'b1, 0, 1'b1, 32'd0, 1'b1);
  endtask

  task automatic report_miss(input string msg);
    failures++;
    if (failures <= 10)
      $display("%s", msg);
  endtask

  always @(posedge clk) begin : watch
    desc_t want;
    if (rst) begin
      max_packet = utdb_pkg::MaxPacketReset;
      desc_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        max_packet = cfg_data;
      if (in_tvalid && in_tready)
        predict_chain(in_tuser[0], in_tdata[0], in_tdata[32:1], in_tdata[64:33],
                      in_tdata[80:65]);
      if (out_tvalid && out_tready) begin
        if (desc_q.size() == 0) begin
          report_miss($sformatf("unexpected beat: tok=%h len=%h buf=%h last=%b fault=%0d",
                                out_tdata[15:0], out_tdata[31:16], out_tdata[63:32],
                                out_tlast, out_tuser));
        end else begin
          want = desc_q.pop_front();
          if (out_tdata[15:0] !== want.token || out_tdata[31:16] !== want.length ||
              out_tdata[63:32] !== want.buffer || out_tlast !== want.final_res ||
              out_tuser !== want.fault)
            report_miss($sformatf({"mismatch: exp tok=%h len=%h buf=%h last=%b fault=%0d",
                                   " got tok=%h len=%h buf=%h last=%b fault=%0d"},
                                  want.token, want.length, want.buffer, want.final_res,
                                  want.fault, out_tdata[15:0], out_tdata[31:16],
                                  out_tdata[63:32], out_tlast, out_tuser));
        end
      end
    end
    pending = desc_q.size();
  end

endmodule

@@ sim/usb_transfer_descriptor_builder_unit_test.sv @@
// Testbench top for the transfer descriptor builder: clock, reset, request and
// config stimulus, result back-pressure and the verdict.
// Depends on utdb_pkg, the builder RTL and utdb_chain_checker.
module usb_transfer_descriptor_builder_unit_test;

  localparam int Settle = 8;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data   = '0;

  int          failures;
  int          pending;
  logic        calm       = 1'b0;
  int unsigned cur_mp     = 64;
  int unsigned stall_left = 0;
  // 9999 picks a random packet size for that phase
  int unsigned plan[8]    = '{1, 2047, 0, 1024, 8, 9999, 3, 9999};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  usb_transfer_descriptor_builder_unit dut (
    .clk(clk), .rst(rst),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  utdb_chain_checker chk (
    .clk(clk), .rst(rst),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic issue_request(input logic op, input logic dir, input logic [31:0] setup_addr,
                               input logic [31:0] data_addr, input logic [15:0] len);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap != 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, len, data_addr, setup_addr, dir};
    do @(posedge clk); while (!in_tready);
  endtask

  // request sized to land near a chosen packet count, with some noise
  task automatic random_request();
    logic        op, dir;
    logic [31:0] data_addr;
    logic [15:0] len;
    int unsigned npk, bytes, lim;
    op        = $urandom_range(0, 1);
    dir       = $urandom_range(0, 1);
    data_addr = ($urandom_range(0, 7) == 0) ? (32'hFFFF_F000 | $urandom) : $urandom;
    if (cur_mp == 0 || $urandom_range(0, 9) == 0) begin
      len = $urandom_range(0, 65535);
    end else begin
      lim = op ? 64 : 62;
      if ($urandom_range(0, 99) < 70)
        npk = $urandom_range(op, 6);
      else
        npk = $urandom_range(op, lim + 2);
      if (npk == 0)
        bytes = 0;
      else if ($urandom_range(0, 3) == 0)
        bytes = npk * cur_mp;
      else
        bytes = (npk - 1) * cur_mp + $urandom_range(1, cur_mp);
      len = (bytes > 65535) ? 16'hFFFF : bytes[15:0];
    end
    issue_request(op, dir, $urandom, data_addr, len);
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_max_packet(input int unsigned value);
    // allow the sequencer to get back to idle before touching the register
    repeat (Settle) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[10:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    cur_mp = value;
  endtask

  initial begin
    #80_000_000;
    $display("FAIL usb_transfer_descriptor_builder_unit");
    $finish;
  end

  initial begin
    int unsigned mp;
    int          n;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed, packet size still at its reset value
    issue_request(1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 16'd0);
    issue_request(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    issue_request(1'b0, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 16'd1);
    issue_request(1'b0, 1'b0, 32'h0000_1000, 32'h0000_2000, 16'd64);
    issue_request(1'b0, 1'b1, 32'h0000_1000, 32'h0000_2000, 16'd65);
    issue_request(1'b0, 1'b0, 32'hAAAA_5555, 32'h5555_AAAA, 16'd3968);
    issue_request(1'b0, 1'b1, 32'hAAAA_5555, 32'h5555_AAAA, 16'd3969);
    issue_request(1'b0, 1'b0, 32'h0000_0040, 32'h0000_0080, 16'hFFFF);
    issue_request(1'b1, 1'b0, 32'h0000_0000, 32'h0001_0000, 16'd0);
    issue_request(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0001_0000, 16'd1);
    issue_request(1'b1, 1'b0, 32'h0000_0000, 32'h8000_0000, 16'd4096);
    issue_request(1'b1, 1'b0, 32'h0000_0000, 32'h8000_0000, 16'd4097);
    issue_request(1'b1, 1'b1, 32'h0000_0000, 32'h8000_0000, 16'hFFFF);
    issue_request(1'b0, 1'b0, 32'h0000_0100, 32'hFFFF_FFF0, 16'd200);
    issue_request(1'b1, 1'b1, 32'hDEAD_BEEF, 32'hFFFF_FFC0, 16'd130);
    issue_request(1'b0, 1'b1, 32'h0000_0300, 32'h0000_0400, 16'd128);
    issue_request(1'b1, 1'b0, 32'h0000_0000, 32'h0000_0500, 16'd63);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      mp = (plan[ph] > 2047) ? $urandom_range(2, 1024) : plan[ph];
      set_max_packet(mp);
      calm = (ph % 3 == 1);
      n    = (mp == 0) ? 16 : 46;
      for (int i = 0; i < n; i++) begin
        // hold off mid-phase until the block has emptied
        if (i == n / 2)
          drain();
        random_request();
      end
    end

    drain();
    repeat (80) @(negedge clk);
    if (failures == 0)
      $display("PASS usb_transfer_descriptor_builder_unit");
    else
      $display("FAIL usb_transfer_descriptor_builder_unit");
    $finish;
  end

endmodule

@@ files.f @@
rtl/utdb_pkg.sv
rtl/utdb_seq.sv
rtl/usb_transfer_descriptor_builder_unit.sv
rtl/utdb_checker.sv
sim/utdb_chain_checker.sv
sim/usb_transfer_descriptor_builder_unit_test.sv
